@@ design/jss_pkg.sv @@
// shared constants, types and arithmetic for the jacobi stencil sweep core
package jss_pkg;

    localparam int VALUE_W  = 32;
    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = 16;
    localparam int GCOL_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

    localparam logic [ROW_W-1:0]  ROWS_RESET = ROW_W'(64);
    localparam logic [GCOL_W-1:0] COLS_RESET = GCOL_W'(64);
    localparam logic [ROW_W-1:0]  ROWS_MIN   = ROW_W'(3);
    localparam logic [GCOL_W-1:0] COLS_MIN   = GCOL_W'(3);
    localparam logic [GCOL_W-1:0] COLS_MAX   = GCOL_W'(MAX_COLS);

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [COL_W-1:0]   col_t;

    // line buffer access for one item
    typedef struct packed {
        logic   rd_en;
        col_t   rd_addr;
        logic   wr_newer_en;
        logic   wr_older_en;
        col_t   wr_addr;
        value_t wr_newer;
        value_t wr_older;
    } lb_ctrl_t;

    // registered line buffer reads
    typedef struct packed {
        value_t centre;
        value_t right;
        value_t up;
    } lb_data_t;

    // exact floor of the four-term sum over four
    function automatic value_t quarter_sum(value_t a, value_t b, value_t c, value_t d);
        logic signed [VALUE_W+1:0] s;
        s = (VALUE_W+2)'($signed(a)) + (VALUE_W+2)'($signed(b))
          + (VALUE_W+2)'($signed(c)) + (VALUE_W+2)'($signed(d));
        return s[VALUE_W+1:2];
    endfunction

endpackage

@@ design/jacobi_stencil_sweep_core.sv @@
// top level: one jacobi sweep of the four-point laplace stencil over a raster stream
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[31:0] = cell_value
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[31:0] = new_value, tlast = frame_last
//  cfg       in   cfg_valid/cfg_ready          cfg_index (0 rows, 1 cols), cfg_data
//
// one input beat per cycle while the output side takes results; a result passes the line buffer
// read register (with the work stage), then the output register
// on the last row each beat yields two results; input waits until the spare slot drains
// the output slot plus a one-deep spare slot hold the two results of a last-row beat
// reset clears positions and sets sizes (64 x 64); row buffers hold garbage until written
module jacobi_stencil_sweep_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // [31:0] cell_value
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [31:0] new_value
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [jss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jss_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // configuration
    logic [jss_pkg::ROW_W-1:0]  grid_rows_reg;
    logic [jss_pkg::GCOL_W-1:0] grid_cols_reg;
    logic [jss_pkg::ROW_W-1:0]  rows_eff;
    logic [jss_pkg::GCOL_W-1:0] cols_eff;

    // raster position
    logic [jss_pkg::ROW_W-1:0]  row_pos_reg, row_pos_next;
    jss_pkg::col_t              col_pos_reg, col_pos_next;
    logic [jss_pkg::GCOL_W-1:0] col_ext;

    logic in_fire, last_row, last_col, has_res, interior, second;

    // work stage
    logic            s1_valid_reg, s1_valid_next;
    jss_pkg::value_t s1_x_reg;
    jss_pkg::col_t   s1_col_reg;
    logic            s1_has_res_reg, s1_interior_reg, s1_second_reg, s1_last_reg;
    jss_pkg::value_t prev_centre_reg;
    logic            s1_go;
    jss_pkg::value_t s1_result;

    // output slots
    logic            out_valid_reg, out_valid_next;
    jss_pkg::value_t out_data_reg, out_data_next;
    logic            out_last_reg, out_last_next;
    logic            pend_valid_reg, pend_valid_next;
    jss_pkg::value_t pend_data_reg, pend_data_next;
    logic            pend_last_reg, pend_last_next;
    logic            out_free;

    jss_pkg::lb_ctrl_t lb_ctrl;
    jss_pkg::lb_data_t lb_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= jss_pkg::ROWS_RESET;
            grid_cols_reg <= jss_pkg::COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                jss_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                jss_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_data[jss_pkg::GCOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rows_eff = (grid_rows_reg < jss_pkg::ROWS_MIN) ? jss_pkg::ROWS_MIN : grid_rows_reg;
        if (grid_cols_reg < jss_pkg::COLS_MIN)
            cols_eff = jss_pkg::COLS_MIN;
        else if (grid_cols_reg > jss_pkg::COLS_MAX)
            cols_eff = jss_pkg::COLS_MAX;
        else
            cols_eff = grid_cols_reg;
    end

    // input side decode
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign col_ext  = jss_pkg::GCOL_W'(col_pos_reg);
    assign last_row = row_pos_reg >= rows_eff - jss_pkg::ROW_W'(1);
    assign last_col = col_ext >= cols_eff - jss_pkg::GCOL_W'(1);
    assign has_res  = row_pos_reg != '0;
    assign second   = last_row && has_res;
    assign interior = (row_pos_reg >= jss_pkg::ROW_W'(2))
                   && (row_pos_reg <= rows_eff - jss_pkg::ROW_W'(1))
                   && (col_pos_reg != '0)
                   && (col_ext <= cols_eff - jss_pkg::GCOL_W'(2));

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (in_fire)
        begin
            if (last_col)
            begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + jss_pkg::ROW_W'(1);
            end
            else
            begin
                col_pos_next = col_pos_reg + jss_pkg::col_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    // stage handshake
    assign out_free      = !pend_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s1_go         = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || s1_go;
    assign s1_valid_next = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_x_reg        <= s_axis_tdata;
            s1_col_reg      <= col_pos_reg;
            s1_has_res_reg  <= has_res;
            s1_interior_reg <= interior;
            s1_second_reg   <= second;
            s1_last_reg     <= last_col;
        end
        // left neighbor is the centre of the previous beat in the same row
        if (s1_go)
            prev_centre_reg <= lb_data.centre;
    end

    always_comb
    begin
        lb_ctrl.rd_en       = in_fire;
        lb_ctrl.rd_addr     = col_pos_reg;
        lb_ctrl.wr_newer_en = s1_go;
        lb_ctrl.wr_older_en = s1_go && s1_has_res_reg;
        lb_ctrl.wr_addr     = s1_col_reg;
        lb_ctrl.wr_newer    = s1_x_reg;
        lb_ctrl.wr_older    = lb_data.centre;
    end

    jss_line_buf u_line_buf
    (
        .clk     (clk),
        .ctrl    (lb_ctrl),
        .rd_data (lb_data)
    );

    assign s1_result = s1_interior_reg
        ? jss_pkg::quarter_sum(lb_data.right, prev_centre_reg, lb_data.up, s1_x_reg)
        : lb_data.centre;

    // output slot and spare slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        pend_last_next  = pend_last_reg;
        if (s1_go && s1_has_res_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = s1_result;
            out_last_next   = 1'b0;
            pend_valid_next = s1_second_reg;
            pend_data_next  = s1_x_reg;
            pend_last_next  = s1_last_reg;
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            if (pend_valid_reg)
            begin
                out_data_next   = pend_data_reg;
                out_last_next   = pend_last_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        pend_data_reg <= pend_data_next;
        pend_last_reg <= pend_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // checks
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("spare slot full while output slot empty");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_second_reg |-> s1_has_res_reg)
        else $error("last-row copy without a stencil result");

    a_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s1_valid_reg |-> s1_go)
        else $error("beat accepted over a held work stage");

    a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && m_axis_tready |=> !pend_valid_reg)
        else $error("spare slot did not move to output");

endmodule

@@ design/jss_line_buf.sv @@
// two row buffers: rows r-1 and r-2 of the incoming raster position
module jss_line_buf
(
    input  logic              clk,
    input  jss_pkg::lb_ctrl_t ctrl,
    output jss_pkg::lb_data_t rd_data
);

    jss_pkg::value_t newer_mem [jss_pkg::MAX_COLS];
    jss_pkg::value_t older_mem [jss_pkg::MAX_COLS];
    jss_pkg::col_t   rd_addr_p1;

    // wraps at the top column, only used for interior cells
    assign rd_addr_p1 = ctrl.rd_addr + jss_pkg::col_t'(1);

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_data.centre <= newer_mem[ctrl.rd_addr];
            rd_data.right  <= newer_mem[rd_addr_p1];
            rd_data.up     <= older_mem[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_newer_en)
        begin
            newer_mem[ctrl.wr_addr] <= ctrl.wr_newer;
        end
        if (ctrl.wr_older_en)
        begin
            older_mem[ctrl.wr_addr] <= ctrl.wr_older;
        end
    end

endmodule

@@ dv/jss_checker.sv @@
`timescale 1ns / 100ps
// checker for the stencil sweep core: predicts every swept cell from input beats and compares
module jss_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [31:0]                    m_axis_tdata,
    input  logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [jss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jss_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             results_seen
);

    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        jss_pkg::value_t cell_val;
        logic            frame_end;
    } swept_cell_t;

    swept_cell_t owed_cells[$];

    // row r-2 and row r-1 as seen by the next incoming cell
    jss_pkg::value_t upper_row [jss_pkg::MAX_COLS];
    jss_pkg::value_t middle_row[jss_pkg::MAX_COLS];

    logic [jss_pkg::ROW_W-1:0]  row_pos;
    jss_pkg::col_t              col_pos;
    logic [jss_pkg::ROW_W-1:0]  rows_reg;
    logic [jss_pkg::GCOL_W-1:0] cols_reg;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // floor of the four-neighbour sum over four, summed exactly in two extra bits
    function automatic jss_pkg::value_t stencil_quarter(jss_pkg::value_t n, jss_pkg::value_t s,
                                                        jss_pkg::value_t w, jss_pkg::value_t e);
        logic signed [jss_pkg::VALUE_W+1:0] total;
        total = $signed({{2{n[jss_pkg::VALUE_W-1]}}, n})
              + $signed({{2{s[jss_pkg::VALUE_W-1]}}, s})
              + $signed({{2{w[jss_pkg::VALUE_W-1]}}, w})
              + $signed({{2{e[jss_pkg::VALUE_W-1]}}, e});
        return total[jss_pkg::VALUE_W+1:2];
    endfunction

    task automatic sweep_cell(input jss_pkg::value_t x);
        int              rows_eff;
        int              cols_eff;
        int              r;
        int              c;
        logic            last_row;
        logic            last_col;
        logic            interior;
        jss_pkg::value_t centre;
        swept_cell_t     res;
        rows_eff = (rows_reg < jss_pkg::ROWS_MIN) ? jss_pkg::ROWS_MIN : rows_reg;
        cols_eff = (cols_reg < jss_pkg::COLS_MIN) ? jss_pkg::COLS_MIN
                 : (cols_reg > jss_pkg::COLS_MAX) ? jss_pkg::COLS_MAX : cols_reg;
        r = row_pos;
        c = col_pos;
        last_row = (r >= rows_eff - 1);
        last_col = (c >= cols_eff - 1);
        if (r >= 1)
        begin
            centre = middle_row[c];
            interior = (r >= 2) && (r + 1 <= rows_eff) && (c >= 1) && (c + 2 <= cols_eff);
            // left neighbor already moved up into the upper row on the previous beat
            res.cell_val = interior ? stencil_quarter(upper_row[c], x, upper_row[c-1],
                                                      middle_row[c+1]) : centre;
            res.frame_end = 1'b0;
            owed_cells.push_back(res);
            upper_row[c] = centre;
        end
        middle_row[c] = x;
        // last row goes out as is, right behind the cell above it
        if (last_row && r >= 1)
        begin
            res.cell_val = x;
            res.frame_end = last_col;
            owed_cells.push_back(res);
        end
        if (last_col)
        begin
            col_pos = '0;
            row_pos = last_row ? '0 : row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        swept_cell_t want;
        if (!rst_n)
        begin
            row_pos  = '0;
            col_pos  = '0;
            rows_reg = jss_pkg::ROWS_RESET;
            cols_reg = jss_pkg::COLS_RESET;
            owed_cells.delete();
            pending  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == jss_pkg::REG_GRID_ROWS)
                    rows_reg = cfg_data[jss_pkg::ROW_W-1:0];
                else if (cfg_index == jss_pkg::REG_GRID_COLS)
                    cols_reg = cfg_data[jss_pkg::GCOL_W-1:0];
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (owed_cells.size() == 0)
                begin
                    report_mismatch("unexpected beat", m_axis_tdata, '0);
                end
                else
                begin
                    want = owed_cells.pop_front();
                    if (m_axis_tdata !== want.cell_val)
                        report_mismatch("new_value", m_axis_tdata, want.cell_val);
                    if (m_axis_tlast !== want.frame_end)
                        report_mismatch("frame_last", 32'(m_axis_tlast), 32'(want.frame_end));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                sweep_cell(s_axis_tdata);
            pending = owed_cells.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// testbench top: reset, size writes, cell stream, output flow control and verdict
module tb_top;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int RANDOM_CELLS  = 1100;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [31:0]                    s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [31:0]                    m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [jss_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [jss_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

    int fail_count;
    int pending;
    int results_seen;
    int cycle_count  = 0;
    int cells_sent   = 0;
    int grids_done   = 0;
    int burst_left   = 0;
    bit hold_request = 1'b0;
    bit hold_done    = 1'b0;

    // five rows of saturated values, then the last row
    jss_pkg::value_t extreme_cells [15] = '{
        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
        32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
        32'h80000000, 32'h80000000, 32'h80000000,
        32'h80000000, 32'h80000000, 32'h80000000
    };
    jss_pkg::value_t closing_cells [3] = '{32'h00000000, 32'hFFFFFFFF, 32'h40000000};
    // centre neighbours sum to -5, so the quarter rounds down to -2
    jss_pkg::value_t rounding_cells [9] = '{
        32'h00000005, 32'hFFFFFFFD, 32'h00000007,
        32'hFFFFFFFF, 32'h80000000, 32'hFFFFFFFF,
        32'h7FFFFFFF, 32'h00000000, 32'h80000000
    };

    always #5 clk = ~clk;

    jacobi_stencil_sweep_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    jss_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    function automatic jss_pkg::value_t pick_cell();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return jss_pkg::value_t'($urandom_range(0, 15)) - jss_pkg::value_t'(8);
            default: return jss_pkg::value_t'($urandom());
        endcase
    endfunction

    function automatic int rows_in_use(logic [jss_pkg::CFG_DATA_W-1:0] word);
        logic [jss_pkg::ROW_W-1:0] rows;
        rows = word[jss_pkg::ROW_W-1:0];
        return (rows < jss_pkg::ROWS_MIN) ? jss_pkg::ROWS_MIN : rows;
    endfunction

    function automatic int cols_in_use(logic [jss_pkg::CFG_DATA_W-1:0] word);
        logic [jss_pkg::GCOL_W-1:0] cols;
        cols = word[jss_pkg::GCOL_W-1:0];
        return (cols < jss_pkg::COLS_MIN) ? jss_pkg::COLS_MIN
             : (cols > jss_pkg::COLS_MAX) ? jss_pkg::COLS_MAX : cols;
    endfunction

    // one beat, then maybe close the burst with a gap
    task automatic send_cell(input jss_pkg::value_t v);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
        cells_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_rows(input int n_rows, input int n_cols);
        repeat (n_rows * n_cols) send_cell(pick_cell());
    endtask

    // drain every owed result, then give row-0 beats time to land in the line buffers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [jss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [jss_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
        $display("TEST FAILED");
        $finish;
    end

    // output side: stall segments of varying density, one long hold-off on request
    initial
    begin
        int seg_len;
        int stall_pct;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                @(posedge clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                seg_len = $urandom_range(10, 150);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    2:       stall_pct = 60;
                    default: stall_pct = 85;
                endcase
                repeat (seg_len)
                begin
                    @(posedge clk);
                    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
                end
            end
        end
    end

    initial
    begin
        int                             first_random;
        logic [jss_pkg::CFG_DATA_W-1:0] rows_word;
        logic [jss_pkg::CFG_DATA_W-1:0] cols_word;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rows stay at the reset value while five rows go in, then shrink so row 5 is last
        write_reg(jss_pkg::REG_GRID_COLS, jss_pkg::CFG_DATA_W'(3));
        foreach (extreme_cells[i])
            send_cell(extreme_cells[i]);
        settle();
        write_reg(jss_pkg::REG_GRID_ROWS, jss_pkg::CFG_DATA_W'(3));
        foreach (closing_cells[i])
            send_cell(closing_cells[i]);
        settle();
        grids_done++;

        // undersized words, junk above the column field
        write_reg(jss_pkg::REG_GRID_ROWS, 16'h0001);
        write_reg(jss_pkg::REG_GRID_COLS, 16'hF802);
        foreach (rounding_cells[i])
            send_cell(rounding_cells[i]);
        settle();
        grids_done++;

        // full-scale row count, cut short after four rows
        write_reg(jss_pkg::REG_GRID_ROWS, 16'hFFFF);
        write_reg(jss_pkg::REG_GRID_COLS, 16'h2803);
        send_rows(4, 3);
        settle();
        write_reg(jss_pkg::REG_GRID_ROWS, 16'h0000);
        send_rows(1, 3);
        settle();
        grids_done++;

        // output held off a while once the random grids start
        hold_request = 1'b1;
        first_random = cells_sent;
        while (cells_sent - first_random < RANDOM_CELLS)
        begin
            rows_word = ($urandom_range(0, 9) == 0)
                      ? jss_pkg::CFG_DATA_W'($urandom_range(0, 2))
                      : jss_pkg::CFG_DATA_W'($urandom_range(3, 8));
            cols_word = jss_pkg::CFG_DATA_W'($urandom());
            case ($urandom_range(0, 9))
                0:       cols_word[jss_pkg::GCOL_W-1:0] = jss_pkg::GCOL_W'($urandom_range(0, 2));
                1:       cols_word[jss_pkg::GCOL_W-1:0] = jss_pkg::GCOL_W'($urandom_range(25, 120));
                default: cols_word[jss_pkg::GCOL_W-1:0] = jss_pkg::GCOL_W'($urandom_range(3, 24));
            endcase
            if ($urandom_range(0, 1))
            begin
                write_reg(jss_pkg::REG_GRID_ROWS, rows_word);
                write_reg(jss_pkg::REG_GRID_COLS, cols_word);
            end
            else
            begin
                write_reg(jss_pkg::REG_GRID_COLS, cols_word);
                write_reg(jss_pkg::REG_GRID_ROWS, rows_word);
            end
            send_rows(rows_in_use(rows_word), cols_in_use(cols_word));
            settle();
            grids_done++;
        end

        repeat (20) @(posedge clk);
        $display("swept %0d cells over %0d grids, %0d result beats checked",
                 cells_sent, grids_done, results_seen);
        $display("grids from 3x3 up to 120 columns, clamped and masked sizes, rows cut mid-grid");
        if (fail_count == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
